@@ rtl/core/multi_buffer_slot_lock_policy_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slot lock policy core
// Shared helpers for clocked, reset-gated property checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUFFER_SLOT_LOCK_POLICY_CORE_MACROS_SVH
`define MULTI_BUFFER_SLOT_LOCK_POLICY_CORE_MACROS_SVH

// same-cycle implication
`define MBSLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbslp check failed");

// next-cycle implication
`define MBSLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbslp check failed");

`endif

@@ rtl/core/mbslp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbslp_pkg
// Types and codes shared by the slot lock policy core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbslp_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int STAMP_W       = 64;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_WRITING = 2'd1;
  localparam logic [1:0] ST_DATA    = 2'd2;
  localparam logic [1:0] ST_READING = 2'd3;

  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  localparam logic [1:0] MODE_WR_NOOVR = 2'd0;
  localparam logic [1:0] MODE_WR_OLD   = 2'd1;
  localparam logic [1:0] MODE_RD_OLD   = 2'd2;
  localparam logic [1:0] MODE_RD_NEW   = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic eval;
    logic newest;
  } pick_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/mbslp_req_if.sv @@
// ----------------------------------------------------------------------------
// mbslp_req_if
// Command channel: lock or unlock request with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbslp_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] lock_mode;
  logic [1:0] slot_index;

  modport source (output valid, output cmd, output lock_mode, output slot_index,
                  input ready);
  modport sink   (input valid, input cmd, input lock_mode, input slot_index,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/mbslp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mbslp_rsp_if
// Result channel: grant, slot and stamp with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbslp_rsp_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [1:0]  chosen_slot;
  logic [63:0] slot_stamp;

  modport source (output valid, output granted, output chosen_slot, output slot_stamp,
                  input ready);
  modport sink   (input valid, input granted, input chosen_slot, input slot_stamp,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/mbslp_mem.sv @@
// ----------------------------------------------------------------------------
// mbslp_mem
// Slot table: status and stamp per slot, one write and one registered read
// port. Per-entry valid bits give the reset value of unwritten slots.
// ----------------------------------------------------------------------------
`default_nettype none

module mbslp_mem #(
  parameter int NUM_SLOTS = 4,
  parameter int IDX_W     = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  rd_en_i,
  input  wire [IDX_W-1:0]      rd_addr_i,
  output mbslp_pkg::entry_t    rd_entry_o,
  input  wire                  wr_en_i,
  input  wire [IDX_W-1:0]      wr_addr_i,
  input  wire mbslp_pkg::entry_t wr_entry_i
);
  import mbslp_pkg::*;

  entry_t               mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;
  entry_t               rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten slot reads as free with stamp zero
  assign rd_entry_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/mbslp_pick.sv @@
// ----------------------------------------------------------------------------
// mbslp_pick
// Scan accumulator: first free slot and the oldest or newest data slot,
// one table entry per cycle while eval is set.
// ----------------------------------------------------------------------------
`default_nettype none

module mbslp_pick #(
  parameter int NUM_SLOTS = 4,
  parameter int IDX_W     = 2
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire mbslp_pkg::pick_ctrl_t ctrl_i,
  input  wire [IDX_W-1:0]            addr_i,
  input  wire mbslp_pkg::entry_t     entry_i,
  output logic                       free_found_o,
  output logic [IDX_W-1:0]           free_idx_o,
  output logic                       data_found_o,
  output logic [IDX_W-1:0]           best_idx_o,
  output logic [mbslp_pkg::STAMP_W-1:0] best_stamp_o
);
  import mbslp_pkg::*;

  logic                free_found_q, data_found_q;
  logic [IDX_W-1:0]    free_idx_q, best_idx_q;
  logic [STAMP_W-1:0]  best_stamp_q;
  logic                take_free, take_data, better;

  assign better    = ctrl_i.newest ? (entry_i.stamp > best_stamp_q)
                                   : (entry_i.stamp < best_stamp_q);
  assign take_free = ctrl_i.eval && !free_found_q && (entry_i.status == ST_FREE);
  assign take_data = ctrl_i.eval && (entry_i.status == ST_DATA) && (!data_found_q || better);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      data_found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      free_found_q <= 1'b0;
      data_found_q <= 1'b0;
    end else begin
      if (take_free) free_found_q <= 1'b1;
      if (take_data) data_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_free) begin
      free_idx_q <= addr_i;
    end
    if (take_data) begin
      best_idx_q   <= addr_i;
      best_stamp_q <= entry_i.stamp;
    end
  end

  assign free_found_o = free_found_q;
  assign free_idx_o   = free_idx_q;
  assign data_found_o = data_found_q;
  assign best_idx_o   = best_idx_q;
  assign best_stamp_o = best_stamp_q;

endmodule

`default_nettype wire

@@ rtl/core/multi_buffer_slot_lock_policy_core.sv @@
// ----------------------------------------------------------------------------
// multi_buffer_slot_lock_policy_core
// Slot lock policy for a multi-buffer exchange. Slot status and write stamps
// live in a table with a registered read port. An unlock reads the slot,
// then writes it back and loads the result register. A lock reads every
// slot in turn through the scan accumulator, waits for the last read to
// return, then decides: it writes the granted slot and loads the result
// register. One command is in flight at a time; the result register lets
// the next command in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_buffer_slot_lock_policy_core_macros.svh"

module multi_buffer_slot_lock_policy_core #(
  parameter int NUM_SLOTS = mbslp_pkg::NUM_SLOTS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  mbslp_req_if.sink    in_i,
  mbslp_rsp_if.source  out_o
);
  import mbslp_pkg::*;

  localparam int               IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_SLOTS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_UNLK   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [1:0]          mode_q;
  logic [IDX_W-1:0]    idx_q;
  logic                oor_q;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic                iss_q, iss_d;
  logic                rv_q;
  logic [IDX_W-1:0]    raddr_q;
  logic [STAMP_W-1:0]  ctr_q;

  logic                out_valid_q, out_granted_q;
  logic [1:0]          out_slot_q;
  logic [STAMP_W-1:0]  out_stamp_q;

  logic                in_xfer, out_free, commit;
  logic                rd_en, wr_en, ctr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  entry_t              rd_entry, wr_entry;
  logic                res_granted;
  logic [IDX_W-1:0]    res_idx;
  logic [STAMP_W-1:0]  res_stamp, ctr_inc;
  pick_ctrl_t          pick_ctrl;
  logic                free_found, data_found;
  logic [IDX_W-1:0]    free_idx, best_idx;
  logic [STAMP_W-1:0]  best_stamp;
  logic                do_free, do_data, wr_lock;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign ctr_inc    = ctr_q + STAMP_W'(1);

  assign do_free = (mode_q == MODE_WR_NOOVR || mode_q == MODE_WR_OLD) && free_found;
  assign do_data = !do_free && (mode_q != MODE_WR_NOOVR) && data_found;
  assign wr_lock = do_free || (do_data && mode_q == MODE_WR_OLD);

  assign pick_ctrl.clear  = in_xfer;
  assign pick_ctrl.eval   = (state_q == S_SCAN) && rv_q;
  assign pick_ctrl.newest = (mode_q == MODE_RD_NEW);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    rd_en       = 1'b0;
    rd_addr     = cnt_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_entry    = '0;
    ctr_en      = 1'b0;
    commit      = 1'b0;
    res_granted = 1'b0;
    res_idx     = '0;
    res_stamp   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rd_en = 1'b1;
          if (in_i.cmd == CMD_UNLOCK) begin
            rd_addr = IDX_W'(in_i.slot_index);
            state_d = S_UNLK;
          end else begin
            rd_addr = '0;
            cnt_d   = IDX_W'(1);
            iss_d   = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_q) begin
          rd_en = 1'b1;
          if (cnt_q == LAST) iss_d = 1'b0;
          else cnt_d = cnt_q + IDX_W'(1);
        end
        if (rv_q && raddr_q == LAST) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
          if (do_free || do_data) begin
            wr_en       = 1'b1;
            res_granted = 1'b1;
            wr_addr     = do_free ? free_idx : best_idx;
            res_idx     = wr_addr;
            if (wr_lock) begin
              ctr_en   = 1'b1;
              wr_entry = '{status: ST_WRITING, stamp: ctr_inc};
              res_stamp = ctr_inc;
            end else begin
              wr_entry  = '{status: ST_READING, stamp: best_stamp};
              res_stamp = best_stamp;
            end
          end
        end
      end
      S_UNLK: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
          if (!oor_q) begin
            wr_en           = 1'b1;
            wr_entry.stamp  = rd_entry.stamp;
            wr_entry.status = (rd_entry.status == ST_READING) ? ST_FREE : ST_DATA;
            res_granted     = 1'b1;
            res_idx         = idx_q;
            res_stamp       = rd_entry.stamp;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      iss_q       <= 1'b0;
      rv_q        <= 1'b0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      rv_q    <= rd_en && (state_d == S_SCAN);
      if (ctr_en) ctr_q <= ctr_inc;
      if (commit) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= rd_addr;
    if (in_xfer) begin
      mode_q <= in_i.lock_mode;
      idx_q  <= IDX_W'(in_i.slot_index);
      oor_q  <= (32'(in_i.slot_index) >= NUM_SLOTS);
    end
    if (commit) begin
      out_granted_q <= res_granted;
      out_slot_q    <= 2'(res_idx);
      out_stamp_q   <= res_stamp;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.granted     = out_granted_q;
  assign out_o.chosen_slot = out_slot_q;
  assign out_o.slot_stamp  = out_stamp_q;

  mbslp_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  mbslp_pick #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (pick_ctrl),
    .addr_i       (raddr_q),
    .entry_i      (rd_entry),
    .free_found_o (free_found),
    .free_idx_o   (free_idx),
    .data_found_o (data_found),
    .best_idx_o   (best_idx),
    .best_stamp_o (best_stamp)
  );

  `MBSLP_ASSERT_NOW(a_reject_zero, out_o.valid && !out_o.granted, out_o.chosen_slot == 2'd0 && out_o.slot_stamp == '0)
  `MBSLP_ASSERT_NEXT(a_one_in_flight, in_xfer, !in_i.ready)
  `MBSLP_ASSERT_NEXT(a_ctr_step, ctr_en, ctr_q == $past(ctr_q) + STAMP_W'(1))
  `MBSLP_ASSERT_NOW(a_no_rw_overlap, wr_en, !rd_en)

endmodule

`default_nettype wire

@@ test/multi_buffer_slot_lock_policy_core_checker.sv @@
// ----------------------------------------------------------------------------
// Slot lock policy checker
// Watches the command and result channels, tracks slot status, write stamps
// and the stamp counter, predicts each grant and compares it, field by
// field, with the result transfers in order.
// ----------------------------------------------------------------------------
module multi_buffer_slot_lock_policy_core_checker #(
  parameter int NUM_SLOTS = mbslp_pkg::NUM_SLOTS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mbslp_req_if  req_i,
  mbslp_rsp_if  rsp_i,
  output int    fail_count_o,
  output int    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbslp_pkg::*;

  typedef struct packed {
    logic               granted;
    logic [1:0]         slot;
    logic [STAMP_W-1:0] stamp;
  } grant_t;

  logic [1:0]         status_q [NUM_SLOTS];
  logic [STAMP_W-1:0] stamp_q [NUM_SLOTS];
  logic [STAMP_W-1:0] stamp_ctr_q;
  grant_t             expected_grants [$];

  function automatic void claim_for_write(int slot);
    stamp_ctr_q    = stamp_ctr_q + 1'b1;
    status_q[slot] = ST_WRITING;
    stamp_q[slot]  = stamp_ctr_q;
  endfunction

  function automatic grant_t predict_grant(logic cmd, logic [1:0] mode, logic [1:0] idx);
    grant_t res;
    int     best;
    bit     found;
    res   = '0;
    best  = 0;
    found = 1'b0;
    if (cmd == CMD_UNLOCK) begin
      if (int'(idx) >= NUM_SLOTS) return res;
      status_q[idx] = (status_q[idx] == ST_READING) ? ST_FREE : ST_DATA;
      res.granted = 1'b1;
      res.slot    = idx;
      res.stamp   = stamp_q[idx];
      return res;
    end
    if (mode == MODE_WR_NOOVR || mode == MODE_WR_OLD) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (status_q[i] == ST_FREE) begin
          claim_for_write(i);
          res.granted = 1'b1;
          res.slot    = 2'(i);
          res.stamp   = stamp_q[i];
          return res;
        end
      end
      if (mode == MODE_WR_NOOVR) return res;
    end
    // lowest index wins on equal stamps
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (status_q[i] == ST_DATA) begin
        if (!found) begin
          found = 1'b1;
          best  = i;
        end else if (mode == MODE_RD_NEW) begin
          if (stamp_q[i] > stamp_q[best]) best = i;
        end else begin
          if (stamp_q[i] < stamp_q[best]) best = i;
        end
      end
    end
    if (!found) return res;
    if (mode == MODE_WR_OLD) claim_for_write(best);
    else status_q[best] = ST_READING;
    res.granted = 1'b1;
    res.slot    = 2'(best);
    res.stamp   = stamp_q[best];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    int     errs;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_q[i] = ST_FREE;
        stamp_q[i]  = '0;
      end
      stamp_ctr_q = '0;
      expected_grants.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      // result transfer first: it always belongs to an older command
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: granted %0d slot %0d stamp %0h",
                 rsp_i.granted, rsp_i.chosen_slot, rsp_i.slot_stamp);
          errs++;
        end else begin
          exp_g = expected_grants.pop_front();
          if (rsp_i.granted !== exp_g.granted) begin
            $error("granted: expected %0d, got %0d", exp_g.granted, rsp_i.granted);
            errs++;
          end
          if (rsp_i.chosen_slot !== exp_g.slot) begin
            $error("chosen_slot: expected %0d, got %0d", exp_g.slot, rsp_i.chosen_slot);
            errs++;
          end
          if (rsp_i.slot_stamp !== exp_g.stamp) begin
            $error("slot_stamp: expected %0h, got %0h", exp_g.stamp, rsp_i.slot_stamp);
            errs++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_grants.push_back(predict_grant(req_i.cmd, req_i.lock_mode,
                                                req_i.slot_index));
      end
      fail_count_o  <= fail_count_o + errs;
      outstanding_o <= expected_grants.size();
    end
  end

endmodule

@@ test/multi_buffer_slot_lock_policy_core_test.sv @@
// ----------------------------------------------------------------------------
// Slot lock policy testbench
// Drives lock and unlock commands into the core: a directed run through
// empty, full, tie and overwrite cases, then random phases under different
// sender and receiver idling, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module multi_buffer_slot_lock_policy_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbslp_pkg::*;

  localparam int PHASE_ITEMS   = 156;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mbslp_req_if req_if ();
  mbslp_rsp_if rsp_if ();

  int   fail_count;
  int   outstanding;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;

  multi_buffer_slot_lock_policy_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  multi_buffer_slot_lock_policy_core_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic offer_command(input logic cmd, input logic [1:0] mode,
                               input logic [1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.lock_mode  <= mode;
    req_if.slot_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic lock_slot(input logic [1:0] mode);
    offer_command(CMD_LOCK, mode, 2'($urandom_range(3)));
  endtask

  task automatic unlock_slot(input logic [1:0] idx);
    offer_command(CMD_UNLOCK, 2'($urandom_range(3)), idx);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int lock_pct;
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_LOCK;
    req_if.lock_mode  = MODE_WR_NOOVR;
    req_if.slot_index = 2'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reads with nothing stored
    lock_slot(MODE_RD_OLD);
    lock_slot(MODE_RD_NEW);
    // unlock of free slots: data with stamp zero, equal stamps
    unlock_slot(2'd2);
    unlock_slot(2'd1);
    lock_slot(MODE_RD_NEW);
    lock_slot(MODE_RD_OLD);
    unlock_slot(2'd1);
    unlock_slot(2'd2);
    // fill every slot for writing
    lock_slot(MODE_WR_NOOVR);
    lock_slot(MODE_WR_NOOVR);
    lock_slot(MODE_WR_OLD);
    lock_slot(MODE_WR_NOOVR);
    lock_slot(MODE_WR_NOOVR);
    lock_slot(MODE_WR_OLD);
    for (int i = 0; i < 4; i++) unlock_slot(2'(i));
    unlock_slot(2'd3);
    // overwrite oldest with no free slot, then reads
    lock_slot(MODE_WR_OLD);
    lock_slot(MODE_RD_NEW);
    lock_slot(MODE_RD_OLD);
    unlock_slot(2'd3);
    unlock_slot(2'd1);
    lock_slot(MODE_WR_OLD);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct   = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct   = 61;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct   = 0;
          recv_stall_pct <= 61;
        end
        default: begin
          send_idle_pct   = 19;
          recv_stall_pct <= 19;
        end
      endcase
      lock_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) lock_pct = 30 + 20 * $urandom_range(2);
        if (phase == 0 && n == 50) hold_req <= ~hold_req;
        offer_command(($urandom_range(99) < lock_pct) ? CMD_LOCK : CMD_UNLOCK,
                      2'($urandom_range(3)), 2'($urandom_range(3)));
      end
      drain_results();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
